[design/assert_macros.svh]
// Assertion helpers shared by the design files.
// Each macro expands to a labeled concurrent assertion for simulation
// and to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: lbl");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[design/spat_pkg.sv]
package spat_pkg;

    // Opcodes of the input transaction
    localparam logic [2:0] OP_LOAD_GLOBAL    = 3'd0;
    localparam logic [2:0] OP_LOAD_LOCAL     = 3'd1;
    localparam logic [2:0] OP_LOAD_DIRECTORY = 3'd2;
    localparam logic [2:0] OP_LOAD_PAGE      = 3'd3;
    localparam logic [2:0] OP_TRANSLATE      = 3'd4;

    // Selector layout
    localparam int SEL_TI_BIT  = 2;
    localparam int SEL_IDX_LO  = 3;
    localparam int SEL_IDX_W   = 13;
    // Wide enough for any selector index and any descriptor count
    localparam int SEL_CMP_W   = SEL_IDX_W + 1;

    // Descriptor layout
    localparam int DESC_P_BIT  = 32 + 15;

    // Paging: one directory and one page table of fixed size
    localparam int PT_ENTRIES  = 1024;
    localparam int PT_AW       = $clog2(PT_ENTRIES);
    localparam int PT_CW       = $clog2(PT_ENTRIES + 1);
    localparam int OFF_W       = 12;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] entry_value;
        logic [31:0] seg_offset;
        logic [15:0] segment_selector;
    } t_in_item;

    typedef struct packed {
        logic        fault;
        logic [31:0] phys_addr;
    } t_out_item;

    // Decoded command kinds passed from front to back
    typedef enum logic [2:0] {
        CK_LOAD_GLOBAL,
        CK_LOAD_LOCAL,
        CK_LOAD_DIRECTORY,
        CK_LOAD_PAGE,
        CK_TRANSLATE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [63:0]            value;
        logic [31:0]            laddr;
        logic                   is_local;
        logic [SEL_IDX_W-1:0]   idx;
        logic                   null_fault;
    } t_cmd;

endpackage

[design/spat_front.sv]
`include "assert_macros.svh"

module spat_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  spat_pkg::t_in_item i_item,
    output spat_pkg::t_cmd     o_cmd,
    output logic               o_cmd_valid,
    input  logic               i_cmd_pop
);
    import spat_pkg::*;

    // Two-entry command queue
    t_cmd       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    t_cmd       cmd;
    logic       cmd_ok;
    logic       enq;
    logic       deq;

    // Classify the incoming transaction
    always_comb begin
        cmd            = '0;
        cmd_ok         = 1'b1;
        cmd.value      = i_item.entry_value;
        cmd.laddr      = i_item.seg_offset;
        cmd.is_local   = i_item.segment_selector[SEL_TI_BIT];
        cmd.idx        = i_item.segment_selector[SEL_IDX_LO +: SEL_IDX_W];
        cmd.null_fault = !cmd.is_local && (cmd.idx == '0);
        unique case (i_item.opcode)
            OP_LOAD_GLOBAL:    cmd.kind = CK_LOAD_GLOBAL;
            OP_LOAD_LOCAL:     cmd.kind = CK_LOAD_LOCAL;
            OP_LOAD_DIRECTORY: cmd.kind = CK_LOAD_DIRECTORY;
            OP_LOAD_PAGE:      cmd.kind = CK_LOAD_PAGE;
            OP_TRANSLATE:      cmd.kind = CK_TRANSLATE;
            default: begin
                // unused opcodes are taken and dropped
                cmd.kind = CK_TRANSLATE;
                cmd_ok   = 1'b0;
            end
        endcase
    end

    assign o_full      = (r_count == 2'd2);
    assign enq         = i_push && !o_full && cmd_ok;
    assign deq         = i_cmd_pop && (r_count != 2'd0);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rptr];

    // Pointer and occupancy update
    always_comb begin
        n_wptr  = r_wptr ^ enq;
        n_rptr  = r_rptr ^ deq;
        n_count = r_count + {1'b0, enq} - {1'b0, deq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wptr] <= cmd;
        end
    end

    `ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, r_count <= 2'd2)
    `ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, (r_count == 2'd2) && !i_cmd_pop, r_count == 2'd2)
    `ASSERT_NEXT(a_empty_holds, i_clk, i_rst_n, (r_count == 2'd0) && !i_push, r_count == 2'd0)

endmodule

[design/spat_back.sv]
`include "assert_macros.svh"

module spat_back #(
    parameter int DESCRIPTOR_ENTRIES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spat_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    output spat_pkg::t_out_item o_item,
    output logic                o_empty,
    input  logic                i_pop
);
    import spat_pkg::*;

    localparam int AW = (DESCRIPTOR_ENTRIES > 1) ? $clog2(DESCRIPTOR_ENTRIES) : 1;
    localparam int CW = $clog2(DESCRIPTOR_ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DESC = 5'b00010,
        S_LIN  = 5'b00100,
        S_PAGE = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]    r_gcount, n_gcount;
    logic [CW-1:0]    r_lcount, n_lcount;
    logic [PT_CW-1:0] r_dcount, n_dcount;
    logic [PT_CW-1:0] r_pcount, n_pcount;

    logic [31:0] r_laddr, n_laddr;
    logic        r_local, n_local;
    logic [31:0] r_lin, n_lin;
    logic        r_fault, n_fault;
    logic [31:0] r_phys, n_phys;
    t_out_item   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    // Memories and their registered read data
    logic [63:0] gd_mem [DESCRIPTOR_ENTRIES];
    logic [63:0] ld_mem [DESCRIPTOR_ENTRIES];
    logic [31:0] dir_mem [PT_ENTRIES];
    logic [31:0] pg_mem [PT_ENTRIES];
    logic [63:0] r_gd_rdata, r_ld_rdata;
    logic [31:0] r_dir_rdata, r_pg_rdata;

    logic                 gd_we, ld_we, dir_we, pg_we;
    logic [AW-1:0]        desc_raddr;
    logic [PT_AW-1:0]     dir_raddr, pg_raddr;
    logic [SEL_CMP_W-1:0] sel_count;
    logic [63:0]          desc;
    logic [31:0]          base;
    logic                 pop_fire;
    logic                 cmd_take;

    assign pop_fire   = i_pop && r_out_valid;
    assign cmd_take   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_cmd_pop  = cmd_take;
    assign desc_raddr = i_cmd.idx[AW-1:0];
    assign dir_raddr  = r_lin[31:22];
    assign pg_raddr   = r_lin[21:12];
    assign sel_count  = i_cmd.is_local ? SEL_CMP_W'(r_lcount) : SEL_CMP_W'(r_gcount);

    // Descriptor fields
    assign desc = r_local ? r_ld_rdata : r_gd_rdata;
    assign base = {desc[63:56], desc[39:32], desc[31:16]};

    // Appends go in only while the table has room
    assign gd_we  = cmd_take && (i_cmd.kind == CK_LOAD_GLOBAL)
                    && (r_gcount < CW'(DESCRIPTOR_ENTRIES));
    assign ld_we  = cmd_take && (i_cmd.kind == CK_LOAD_LOCAL)
                    && (r_lcount < CW'(DESCRIPTOR_ENTRIES));
    assign dir_we = cmd_take && (i_cmd.kind == CK_LOAD_DIRECTORY)
                    && (r_dcount < PT_CW'(PT_ENTRIES));
    assign pg_we  = cmd_take && (i_cmd.kind == CK_LOAD_PAGE)
                    && (r_pcount < PT_CW'(PT_ENTRIES));

    // Sequencer: descriptor read, linear add, table reads, result
    always_comb begin
        n_state     = r_state;
        n_gcount    = r_gcount + CW'(gd_we);
        n_lcount    = r_lcount + CW'(ld_we);
        n_dcount    = r_dcount + PT_CW'(dir_we);
        n_pcount    = r_pcount + PT_CW'(pg_we);
        n_laddr     = r_laddr;
        n_local     = r_local;
        n_lin       = r_lin;
        n_fault     = r_fault;
        n_phys      = r_phys;
        n_out       = r_out;
        n_out_valid = r_out_valid && !pop_fire;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_take && (i_cmd.kind == CK_TRANSLATE)) begin
                    n_laddr = i_cmd.laddr;
                    n_local = i_cmd.is_local;
                    n_phys  = '0;
                    if (i_cmd.null_fault || (SEL_CMP_W'(i_cmd.idx) >= sel_count)) begin
                        n_fault = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_fault = 1'b0;
                        n_state = S_DESC;
                    end
                end
            end
            S_DESC: begin
                n_lin = base + r_laddr;
                if (!desc[DESC_P_BIT]) begin
                    n_fault = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LIN;
                end
            end
            S_LIN: begin
                // table reads issue here; index bounds checked alongside
                if ((PT_CW'(dir_raddr) >= r_dcount) || (PT_CW'(pg_raddr) >= r_pcount)) begin
                    n_fault = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_PAGE;
                end
            end
            S_PAGE: begin
                if (!r_dir_rdata[0] || !r_pg_rdata[0]) begin
                    n_fault = 1'b1;
                end else begin
                    n_phys = {r_pg_rdata[31:OFF_W], r_lin[OFF_W-1:0]};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || pop_fire) begin
                    n_out.fault     = r_fault;
                    n_out.phys_addr = r_fault ? '0 : r_phys;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gcount    <= '0;
            r_lcount    <= '0;
            r_dcount    <= '0;
            r_pcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gcount    <= n_gcount;
            r_lcount    <= n_lcount;
            r_dcount    <= n_dcount;
            r_pcount    <= n_pcount;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_laddr <= n_laddr;
        r_local <= n_local;
        r_lin   <= n_lin;
        r_fault <= n_fault;
        r_phys  <= n_phys;
        r_out   <= n_out;
    end

    // Global descriptor table
    always_ff @(posedge i_clk) begin
        if (gd_we) begin
            gd_mem[r_gcount[AW-1:0]] <= i_cmd.value;
        end
        r_gd_rdata <= gd_mem[desc_raddr];
    end

    // Local descriptor table
    always_ff @(posedge i_clk) begin
        if (ld_we) begin
            ld_mem[r_lcount[AW-1:0]] <= i_cmd.value;
        end
        r_ld_rdata <= ld_mem[desc_raddr];
    end

    // Page directory
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[r_dcount[PT_AW-1:0]] <= i_cmd.value[31:0];
        end
        r_dir_rdata <= dir_mem[dir_raddr];
    end

    // Page table
    always_ff @(posedge i_clk) begin
        if (pg_we) begin
            pg_mem[r_pcount[PT_AW-1:0]] <= i_cmd.value[31:0];
        end
        r_pg_rdata <= pg_mem[pg_raddr];
    end

    assign o_item  = r_out;
    assign o_empty = !r_out_valid;

    `ASSERT_ALWAYS(a_gcount_max, i_clk, i_rst_n, r_gcount <= CW'(DESCRIPTOR_ENTRIES))
    `ASSERT_ALWAYS(a_pcount_max, i_clk, i_rst_n, r_pcount <= PT_CW'(PT_ENTRIES))
    `ASSERT_IMPLY(a_fault_zero, i_clk, i_rst_n, r_out_valid && r_out.fault, r_out.phys_addr == '0)
    `ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n, (r_state == S_DONE) && (n_state == S_IDLE), r_out_valid)

endmodule

[design/segment_page_address_translator_unit.sv]
// Segment and page address translator.
// Input channel: drive i_item and raise push; the transaction is taken on a
// clock edge with push high and full low. Opcodes 0-3 append an entry to the
// global, local, directory or page table (ignored when that table is full);
// opcode 4 translates; other opcodes are taken and dropped.
// Result channel: one result per translate, oldest first, on o_item while
// empty is low; it is taken on an edge with pop high and empty low.
// A translate taken while the block is idle goes through the queue, the
// descriptor read, the linear add, the directory/page reads and the result;
// a null or out-of-range selector fault goes from the queue straight to the
// result. A load is written into its table as the idle back end takes it.
// The back-end sequencer works on one command at a time, taking the next when idle.
// A two-entry command queue between front and back keeps push accepting
// while the back end works or while a result waits to be popped; when pop
// stays low, the back end holds its next result and full rises once the
// queue fills. Reset (synchronous, active low) empties both queues and
// clears the table counts; table contents are not cleared and no clearing
// pass is needed.
module segment_page_address_translator_unit #(
    parameter int DESCRIPTOR_ENTRIES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  spat_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output spat_pkg::t_out_item o_item
);
    import spat_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    // Front: accept and decode
    spat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: tables, translation and result register
    spat_back #(
        .DESCRIPTOR_ENTRIES (DESCRIPTOR_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_item      (o_item),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
